// File: design/rde_pkg.sv
// ----------------------------------------------------------------------------
// rde_pkg
// Shared types, constants and the reciprocal table for the radix digit
// emitter.
// ----------------------------------------------------------------------------
package rde_pkg;

    localparam int VALUE_W = 32;
    localparam int DIGIT_W = 5;
    localparam int RADIX_W = 5;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the input magnitude and sign
        logic mul;     // multiply magnitude by the base reciprocal
        logic fix;     // correct the quotient, push the remainder
        logic pop;     // read the top of the stack into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic value_zero;   // input value is zero
        logic quot_zero;    // corrected quotient is zero
        logic stack_empty;  // no digit left on the stack
    } t_status;

    // floor(2^32 / b) for b in 2..16; the caller clamps b into that range.
    function automatic logic [VALUE_W-1:0] rde_recip(input logic [RADIX_W-1:0] b);
        logic [VALUE_W-1:0] r;
        case (b)
            5'd2:    r = 32'h8000_0000;
            5'd3:    r = 32'h5555_5555;
            5'd4:    r = 32'h4000_0000;
            5'd5:    r = 32'h3333_3333;
            5'd6:    r = 32'h2AAA_AAAA;
            5'd7:    r = 32'h2492_4924;
            5'd8:    r = 32'h2000_0000;
            5'd9:    r = 32'h1C71_C71C;
            5'd10:   r = 32'h1999_9999;
            5'd11:   r = 32'h1745_D174;
            5'd12:   r = 32'h1555_5555;
            5'd13:   r = 32'h13B1_3B13;
            5'd14:   r = 32'h1249_2492;
            5'd15:   r = 32'h1111_1111;
            default: r = 32'h1000_0000;
        endcase
        return r;
    endfunction

endpackage

// File: design/radix_digit_emitter_unit.sv
// ----------------------------------------------------------------------------
// radix_digit_emitter_unit
// Converts a signed 32-bit integer into its digits in a base from 2 to 16.
// ----------------------------------------------------------------------------
// Each accepted value is split into digits, most significant first, with the
// final digit flagged by o_last_digit; negative values give negated digits and
// zero gives no output at all. The base setting is clamped when used: 0 and 1
// act as 2 and anything above 16 as 16. One value is handled at a time: for
// each digit the divide loop runs a 32x32 reciprocal multiply, then a narrow
// remainder correction and stack push; a first stack read follows, and the
// digits are then handed out, each transfer waiting for the sink to be ready.
// Only the least significant MAX_DIGITS digits are kept.
module radix_digit_emitter_unit import rde_pkg::*; #(
    parameter int MAX_DIGITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [RADIX_W-1:0]        i_cfg_wdata,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [DIGIT_W-1:0] o_digit,
    output logic                      o_last_digit
);

    t_cmd    w_cmd;
    t_status w_status;

    rde_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid)
    );

    rde_datapath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_value      (i_value),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_digit      (o_digit),
        .o_last_digit (o_last_digit)
    );

    // The block never offers a digit while it takes a new value.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a digit is offered");

    // A zero value produces nothing and leaves the block ready.
    a_zero_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_value == '0)) |=> (o_in_ready && !o_out_valid))
        else $error("zero value did not return to ready");

    // After the final digit the block goes back to waiting for input.
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last_digit) |=> (o_in_ready && !o_out_valid))
        else $error("no return to ready after the last digit");

    // Any other digit transfer is followed by the next digit.
    a_more_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last_digit) |=> o_out_valid)
        else $error("digit sequence ended without a last flag");

endmodule

// File: design/rde_ctrl.sv
// ----------------------------------------------------------------------------
// rde_ctrl
// Sequencer for the digit emitter: division loop, then stack unwind.
// ----------------------------------------------------------------------------
module rde_ctrl import rde_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_ready,
    output logic    o_out_valid
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_FIX  = 5'b00100,
        S_READ = 5'b01000,
        S_SHOW = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                // A zero value has no digits and is simply dropped.
                if (i_in_valid && !i_status.value_zero) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_FIX;
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = i_status.quot_zero ? S_READ : S_MUL;
            end
            S_READ: begin
                o_cmd.pop = 1'b1;
                n_state   = S_SHOW;
            end
            S_SHOW: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_status.stack_empty) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.pop = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: design/rde_datapath.sv
// ----------------------------------------------------------------------------
// rde_datapath
// Radix register, reciprocal divider, digit stack and output register.
// ----------------------------------------------------------------------------
module rde_datapath import rde_pkg::*; #(
    parameter int MAX_DIGITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [RADIX_W-1:0]        i_cfg_wdata,
    input  logic signed [VALUE_W-1:0] i_value,
    input  t_cmd                      i_cmd,
    output t_status                   o_status,
    output logic signed [DIGIT_W-1:0] o_digit,
    output logic                      o_last_digit
);

    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int AW = $clog2(MAX_DIGITS);

    logic [RADIX_W-1:0]   r_radix;
    logic [RADIX_W-1:0]   r_base;
    logic [VALUE_W-1:0]   r_recip;
    logic [VALUE_W-1:0]   r_mag;
    logic                 r_neg;
    logic [2*VALUE_W-1:0] r_prod;
    logic [CW-1:0]        r_cnt;
    logic [DIGIT_W-1:0]   r_rd;
    logic                 r_last;
    logic [DIGIT_W-1:0]   r_mem [MAX_DIGITS];

    logic [RADIX_W-1:0] w_eff;
    logic [VALUE_W-1:0] w_q0;
    logic [11:0]        w_qb;
    logic [5:0]         w_rem;
    logic [5:0]         w_rem_fix;
    logic               w_fix_up;
    logic [VALUE_W-1:0] w_quot;
    logic [DIGIT_W-1:0] w_digit;
    logic [CW-1:0]      w_top;

    always_comb begin
        if (r_radix < RADIX_MIN) begin
            w_eff = RADIX_MIN;
        end else if (r_radix > RADIX_MAX) begin
            w_eff = RADIX_MAX;
        end else begin
            w_eff = r_radix;
        end
    end

    // The reciprocal quotient is low by at most one. The remainder stays below
    // twice the base, so six low bits of the product are enough to find it.
    always_comb begin
        w_q0      = r_prod[2*VALUE_W-1:VALUE_W];
        w_qb      = {6'd0, w_q0[5:0]} * {7'd0, r_base};
        w_rem     = r_mag[5:0] - w_qb[5:0];
        w_fix_up  = (w_rem >= {1'b0, r_base});
        w_rem_fix = w_fix_up ? (w_rem - {1'b0, r_base}) : w_rem;
        w_quot    = w_q0 + {{(VALUE_W-1){1'b0}}, w_fix_up};
        // The remainder carries the sign of the dividend.
        w_digit   = r_neg ? (5'd0 - {1'b0, w_rem_fix[3:0]}) : {1'b0, w_rem_fix[3:0]};
        w_top     = r_cnt - CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
            r_cnt   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_radix <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_cnt <= '0;
            end else if (i_cmd.fix && (r_cnt < CW'(MAX_DIGITS))) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_cmd.pop) begin
                r_cnt <= w_top;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg   <= i_value[VALUE_W-1];
            r_mag   <= i_value[VALUE_W-1] ? (32'd0 - i_value) : i_value;
            r_base  <= w_eff;
            r_recip <= rde_recip(w_eff);
        end else if (i_cmd.fix) begin
            r_mag <= w_quot;
        end
        if (i_cmd.mul) begin
            r_prod <= {32'd0, r_mag} * {32'd0, r_recip};
        end
    end

    // Digit stack; the registered read doubles as the output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.fix && (r_cnt < CW'(MAX_DIGITS))) begin
            r_mem[r_cnt[AW-1:0]] <= w_digit;
        end
        if (i_cmd.pop) begin
            r_rd   <= r_mem[w_top[AW-1:0]];
            r_last <= (w_top == '0);
        end
    end

    assign o_status.value_zero  = (i_value == '0);
    assign o_status.quot_zero   = (w_quot == '0);
    assign o_status.stack_empty = (r_cnt == '0);
    assign o_digit              = r_rd;
    assign o_last_digit         = r_last;

endmodule
